[rtl/clipped_pixel_alpha_blend_defines.svh]
// Assertion macros shared by the checker files of the pixel blend block
`ifndef CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH
`define CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define CPAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpab: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define CPAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpab: next-cycle check failed");

`endif

[rtl/cpab_pkg.sv]
// Types, constants and helper functions of the clipped pixel alpha blend block
package cpab_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CFG_BITS      = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int ADDR_BITS     = 22;
    localparam int RECIP_BITS    = 17;
    localparam int RECIP_SHIFT   = 16;
    localparam int DIV7_BITS     = 14;
    localparam int DIV7_SHIFT    = 16;
    localparam logic [DIV7_BITS-1:0] DIV7_MUL = 14'd9363;

    // Pixel modes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_BLEND = 2'd1;

    localparam logic [2:0] ALPHA_FULL = 3'd7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PIXEL_MODE  = 3'd0,
        REG_CLIP_MIN_X  = 3'd1,
        REG_CLIP_MAX_X  = 3'd2,
        REG_CLIP_MIN_Y  = 3'd3,
        REG_CLIP_MAX_Y  = 3'd4,
        REG_LINE_STRIDE = 3'd5
    } t_cfg_reg;

    // One pixel write request
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [31:0]                  src_argb;
        logic [15:0]                  dst_rgb565;
        logic [2:0]                   dst_alpha;
    } t_pix_in;

    // One pixel write result
    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_BITS-1:0] pixel_address;
        logic [ADDR_BITS-2:0] alpha_byte_address;
        logic                 alpha_low_nibble;
        logic [15:0]          new_rgb565;
        logic [2:0]           new_alpha;
    } t_pix_out;

    // Truncate a 32-bit ARGB colour to RGB565
    function automatic logic [15:0] argb_to_565(input logic [31:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    // Combined alpha s + d - floor(s*d/7); s*d/7 via multiply by 37/256
    function automatic logic [2:0] blend_alpha(input logic [2:0] s, input logic [2:0] d);
        logic [5:0]  p;
        logic [11:0] q;
        logic [3:0]  a;
        p = s * d;
        q = 12'(p) * 12'd37;
        a = 4'(s) + 4'(d) - 4'(q[11:8]);
        return a[2:0];
    endfunction

    // ceil(2^16 / a) for the divisor a = 1..7
    function automatic logic [RECIP_BITS-1:0] recip(input logic [2:0] a);
        logic [RECIP_BITS-1:0] r;
        unique case (a)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            3'd6:    r = 17'd10923;
            3'd7:    r = 17'd9363;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/clipped_pixel_alpha_blend.sv]
// Top level of the clipped pixel writer with 3-bit alpha blending
//
// Input channel: i_in_valid / o_in_stall carry one pixel write (i_in_data).
// Output channel: o_out_valid / i_out_stall carry one result (o_out_data)
// for every accepted item, in order. An item moves at a clock edge where
// valid is high and stall is low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (mode, clip window, line stride); write only while the pipeline is empty.
// Stage A loads at the accepting edge and the item moves on through B, C and D
// to o_out_valid. Throughput: one item per clock unless the output stalls.
// The four stages are operand products and row address, weighted products and
// address add, divide by 7 and channel sums, and divide by the combined alpha
// through a reciprocal multiply with packing.
// Reset (synchronous, active low) empties the pipeline and loads the
// configuration defaults: copy mode, window 0..2047 on both axes, stride 720.
// Output stall: the result holds; each stage keeps filling until the stage in
// front of it is full, then o_in_stall rises. Bubbles are squeezed out.
module clipped_pixel_alpha_blend (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  cpab_pkg::t_pix_in                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output cpab_pkg::t_pix_out                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [cpab_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cpab_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int CB = cpab_pkg::COORD_BITS;
    localparam int AB = cpab_pkg::ADDR_BITS;

    // Control that travels with each item
    typedef struct packed {
        logic        we;
        logic        mix;
        logic [15:0] plain_rgb;
        logic [2:0]  plain_alpha;
        logic [2:0]  mix_alpha;
        logic        x_lsb;
    } t_ctl;

    // Configuration registers; the window ends hold 2048 after reset
    logic [1:0]    r_pixel_mode;
    logic [CB-1:0] r_clip_min_x;
    logic [CB:0]   r_clip_max_x;
    logic [CB-1:0] r_clip_min_y;
    logic [CB:0]   r_clip_max_y;
    logic [CB-1:0] r_line_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode  <= cpab_pkg::MODE_COPY;
            r_clip_min_x  <= CB'(0);
            r_clip_max_x  <= (CB+1)'(2048);
            r_clip_min_y  <= CB'(0);
            r_clip_max_y  <= (CB+1)'(2048);
            r_line_stride <= CB'(720);
        end else if (i_cfg_we) begin
            unique case (cpab_pkg::t_cfg_reg'(i_cfg_index))
                cpab_pkg::REG_PIXEL_MODE:  r_pixel_mode  <= i_cfg_data[1:0];
                cpab_pkg::REG_CLIP_MIN_X:  r_clip_min_x  <= CB'(i_cfg_data);
                cpab_pkg::REG_CLIP_MAX_X:  r_clip_max_x  <= {1'b0, i_cfg_data};
                cpab_pkg::REG_CLIP_MIN_Y:  r_clip_min_y  <= CB'(i_cfg_data);
                cpab_pkg::REG_CLIP_MAX_Y:  r_clip_max_y  <= {1'b0, i_cfg_data};
                cpab_pkg::REG_LINE_STRIDE: r_line_stride <= CB'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Stage valid bits and ready chain
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d      = !r_d_vld || !i_out_stall;
    assign rdy_c      = !r_c_vld || rdy_d;
    assign rdy_b      = !r_b_vld || rdy_c;
    assign rdy_a      = !r_a_vld || rdy_b;
    assign o_in_stall = !rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_in_valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
        end
    end

    // Stage A: clip test, mode decode, operand products, row address
    logic signed [CB+1:0] x_ext, y_ext;
    logic               in_win;
    logic [2:0]         sa;
    logic [7:0]         src_ch [3];
    logic [7:0]         old_ch [3];
    t_ctl               n_a_ctl;
    logic [10:0]        n_a_src_s [3];
    logic [10:0]        n_a_old_d [3];
    logic [2*CB-1:0]    row_prod;

    always_comb begin
        x_ext  = {{2{i_in_data.pos_x[CB-1]}}, i_in_data.pos_x};
        y_ext  = {{2{i_in_data.pos_y[CB-1]}}, i_in_data.pos_y};
        in_win = (x_ext >= $signed({2'b00, r_clip_min_x}))
              && (y_ext >= $signed({2'b00, r_clip_min_y}))
              && (x_ext <  $signed({1'b0, r_clip_max_x}))
              && (y_ext <  $signed({1'b0, r_clip_max_y}));
        sa     = i_in_data.src_argb[31:29];

        n_a_ctl.we = in_win && ((r_pixel_mode == cpab_pkg::MODE_COPY)
                 || ((r_pixel_mode == cpab_pkg::MODE_BLEND) && (sa != 3'd0)));
        n_a_ctl.mix = (r_pixel_mode == cpab_pkg::MODE_BLEND) && (sa != cpab_pkg::ALPHA_FULL);
        n_a_ctl.plain_rgb   = cpab_pkg::argb_to_565(i_in_data.src_argb);
        n_a_ctl.plain_alpha = (r_pixel_mode == cpab_pkg::MODE_COPY) ? sa
                                                                     : cpab_pkg::ALPHA_FULL;
        n_a_ctl.mix_alpha   = cpab_pkg::blend_alpha(sa, i_in_data.dst_alpha);
        n_a_ctl.x_lsb       = i_in_data.pos_x[0];

        src_ch[0] = i_in_data.src_argb[23:16];
        src_ch[1] = i_in_data.src_argb[15:8];
        src_ch[2] = i_in_data.src_argb[7:0];
        old_ch[0] = {i_in_data.dst_rgb565[15:11], 3'b000};
        old_ch[1] = {i_in_data.dst_rgb565[10:5], 2'b00};
        old_ch[2] = {i_in_data.dst_rgb565[4:0], 3'b000};
        for (int i = 0; i < 3; i++) begin
            n_a_src_s[i] = 11'(src_ch[i]) * 11'(sa);
            n_a_old_d[i] = 11'(old_ch[i]) * 11'(i_in_data.dst_alpha);
        end

        row_prod = (2*CB)'(i_in_data.pos_y) * (2*CB)'(r_line_stride);
    end

    t_ctl          r_a_ctl;
    logic [2:0]    r_a_sa;
    logic [10:0]   r_a_src_s [3];
    logic [10:0]   r_a_old_d [3];
    logic [AB-1:0] r_a_row;
    logic [CB-1:0] r_a_x;

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_ctl   <= n_a_ctl;
            r_a_sa    <= sa;
            r_a_src_s <= n_a_src_s;
            r_a_old_d <= n_a_old_d;
            r_a_row   <= AB'(row_prod);
            r_a_x     <= i_in_data.pos_x;
        end
    end

    // Stage B: triple product for the overlap term, full pixel address
    logic [cpab_pkg::DIV7_BITS-1:0] n_b_ods [3];
    logic [AB-1:0]                  n_b_addr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_ods[i] = cpab_pkg::DIV7_BITS'(r_a_old_d[i]) * cpab_pkg::DIV7_BITS'(r_a_sa);
        end
        n_b_addr = r_a_row + AB'(r_a_x);
    end

    t_ctl                           r_b_ctl;
    logic [10:0]                    r_b_src_s [3];
    logic [10:0]                    r_b_old_d [3];
    logic [cpab_pkg::DIV7_BITS-1:0] r_b_ods [3];
    logic [AB-1:0]                  r_b_addr;

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_ctl   <= r_a_ctl;
            r_b_src_s <= r_a_src_s;
            r_b_old_d <= r_a_old_d;
            r_b_ods   <= n_b_ods;
            r_b_addr  <= n_b_addr;
        end
    end

    // Stage C: divide the overlap by 7, form the weighted channel sums
    localparam int P7_BITS = 2 * cpab_pkg::DIV7_BITS;
    logic [P7_BITS-1:0] p7 [3];
    logic [11:0]        n_c_num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p7[i]      = P7_BITS'(r_b_ods[i]) * P7_BITS'(cpab_pkg::DIV7_MUL);
            n_c_num[i] = 12'(r_b_src_s[i]) + 12'(r_b_old_d[i])
                       - 12'(p7[i][P7_BITS-1:cpab_pkg::DIV7_SHIFT]);
        end
    end

    t_ctl          r_c_ctl;
    logic [11:0]   r_c_num [3];
    logic [AB-1:0] r_c_addr;

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_ctl  <= r_b_ctl;
            r_c_num  <= n_c_num;
            r_c_addr <= r_b_addr;
        end
    end

    // Stage D: divide by the combined alpha, saturate, pack the result
    localparam int PQ_BITS = 12 + cpab_pkg::RECIP_BITS;
    logic [cpab_pkg::RECIP_BITS-1:0] rcp;
    logic [PQ_BITS-1:0]              pq [3];
    logic [PQ_BITS-cpab_pkg::RECIP_SHIFT-1:0] quo [3];
    logic [7:0]                      chan [3];
    cpab_pkg::t_pix_out              n_d_data;

    always_comb begin
        rcp = cpab_pkg::recip(r_c_ctl.mix_alpha);
        for (int i = 0; i < 3; i++) begin
            pq[i]   = PQ_BITS'(r_c_num[i]) * PQ_BITS'(rcp);
            quo[i]  = pq[i][PQ_BITS-1:cpab_pkg::RECIP_SHIFT];
            chan[i] = (quo[i] > (PQ_BITS-cpab_pkg::RECIP_SHIFT)'(255)) ? 8'hff
                                                                       : quo[i][7:0];
        end

        n_d_data = '0;
        if (r_c_ctl.we) begin
            n_d_data.write_enable       = 1'b1;
            n_d_data.pixel_address      = r_c_addr;
            n_d_data.alpha_byte_address = r_c_addr[AB-1:1];
            n_d_data.alpha_low_nibble   = r_c_ctl.x_lsb;
            if (r_c_ctl.mix) begin
                n_d_data.new_rgb565 = {chan[0][7:3], chan[1][7:2], chan[2][7:3]};
                n_d_data.new_alpha  = r_c_ctl.mix_alpha;
            end else begin
                n_d_data.new_rgb565 = r_c_ctl.plain_rgb;
                n_d_data.new_alpha  = r_c_ctl.plain_alpha;
            end
        end
    end

    cpab_pkg::t_pix_out r_d_data;

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_data <= n_d_data;
        end
    end

    assign o_out_valid = r_d_vld;
    assign o_out_data  = r_d_data;

endmodule

[rtl/cpab_checker.sv]
// Port-level assertion checker for the pixel blend block, with its bind
`include "clipped_pixel_alpha_blend_defines.svh"

module cpab_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cpab_pkg::t_pix_out o_out_data
);

    // Hold a stalled result
    `CPAB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Push back on the input only when the full pipeline is blocked at the output
    `CPAB_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // Drop all fields of a pixel that is not written
    `CPAB_ASSERT_IMP(a_no_write_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.write_enable, o_out_data.pixel_address == '0 && o_out_data.new_rgb565 == '0 && o_out_data.new_alpha == '0 && o_out_data.alpha_low_nibble == 1'b0)

    // Keep the alpha byte address at half the pixel address
    `CPAB_ASSERT_IMP(a_byte_addr, i_clk, i_rst_n, o_out_valid, o_out_data.alpha_byte_address == o_out_data.pixel_address[cpab_pkg::ADDR_BITS-1:1])

endmodule

bind clipped_pixel_alpha_blend cpab_checker u_cpab_checker (.*);

[verif/pixel_write_checker.sv]
`timescale 1ns / 100ps
// Checker for the clipped pixel writer: tracks the registers, predicts every write, compares
module pixel_write_checker
    import cpab_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_pix_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_pix_out i_out_data,
    input  logic     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic     i_end_check,
    output int       o_errors,
    output int       o_pending,
    output int       o_checked
);

    localparam logic [CFG_BITS:0]   CLIP_MAX_DEFAULT = 13'd2048;
    localparam logic [CFG_BITS-1:0] STRIDE_DEFAULT   = 12'd720;

    // Register copy seen on the configuration port; window ends hold 2048 after reset
    logic [1:0]          pixel_mode;
    logic [CFG_BITS-1:0] clip_min_x;
    logic [CFG_BITS:0]   clip_max_x;
    logic [CFG_BITS-1:0] clip_min_y;
    logic [CFG_BITS:0]   clip_max_y;
    logic [CFG_BITS-1:0] line_stride;

    t_pix_out expected_writes[$];
    bit       end_done = 1'b0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // Weighted channel over the combined alpha, saturated to 8 bits
    function automatic int blend_channel(int src, int old, int s, int d, int a);
        int num;
        int r;
        num = src * s + old * d - (old * d * s) / int'(ALPHA_FULL);
        r   = num / a;
        return (r > 255) ? 255 : r;
    endfunction

    // Work out the write that one pixel request causes
    function automatic t_pix_out predict_pixel_write(t_pix_in p);
        t_pix_out   res;
        int         x;
        int         y;
        int         s;
        int         d;
        int         a;
        logic [7:0] rc;
        logic [7:0] gc;
        logic [7:0] bc;
        logic [2:0] sa;
        logic       we;
        logic [15:0] rgb;
        logic [2:0] alpha;
        longint     addr;
        logic [63:0] addr_bits;
        res   = '0;
        we    = 1'b0;
        rgb   = '0;
        alpha = '0;
        x  = $signed(p.pos_x);
        y  = $signed(p.pos_y);
        sa = p.src_argb[31:29];
        if (x < int'(clip_min_x) || y < int'(clip_min_y) ||
            x >= int'(clip_max_x) || y >= int'(clip_max_y)) begin
            return res;
        end
        if (pixel_mode == MODE_COPY) begin
            we    = 1'b1;
            rgb   = {p.src_argb[23:19], p.src_argb[15:10], p.src_argb[7:3]};
            alpha = sa;
        end else if (pixel_mode == MODE_BLEND) begin
            if (sa == ALPHA_FULL) begin
                we    = 1'b1;
                rgb   = {p.src_argb[23:19], p.src_argb[15:10], p.src_argb[7:3]};
                alpha = ALPHA_FULL;
            end else if (sa != 3'd0) begin
                s  = int'(sa);
                d  = int'(p.dst_alpha);
                a  = s + d - (s * d) / int'(ALPHA_FULL);
                rc = 8'(blend_channel(int'(p.src_argb[23:16]),
                                      int'({p.dst_rgb565[15:11], 3'b000}), s, d, a));
                gc = 8'(blend_channel(int'(p.src_argb[15:8]),
                                      int'({p.dst_rgb565[10:5], 2'b00}), s, d, a));
                bc = 8'(blend_channel(int'(p.src_argb[7:0]),
                                      int'({p.dst_rgb565[4:0], 3'b000}), s, d, a));
                we    = 1'b1;
                rgb   = {rc[7:3], gc[7:2], bc[7:3]};
                alpha = 3'(a);
            end
        end
        if (we) begin
            // Inside the window both coordinates are non-negative; wrap to the widths
            addr      = longint'(y) * longint'(line_stride) + longint'(x);
            addr_bits = addr;
            res.write_enable       = 1'b1;
            res.pixel_address      = addr_bits[ADDR_BITS-1:0];
            res.alpha_byte_address = addr_bits[ADDR_BITS-1:1];
            res.alpha_low_nibble   = p.pos_x[0];
            res.new_rgb565         = rgb;
            res.new_alpha          = alpha;
        end
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h want 0x%0h (result %0d)",
                 $realtime, what, got, want, o_checked);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            pixel_mode  = MODE_COPY;
            clip_min_x  = '0;
            clip_max_x  = CLIP_MAX_DEFAULT;
            clip_min_y  = '0;
            clip_max_y  = CLIP_MAX_DEFAULT;
            line_stride = STRIDE_DEFAULT;
            expected_writes.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PIXEL_MODE:  pixel_mode  = i_cfg_data[1:0];
                    REG_CLIP_MIN_X:  clip_min_x  = i_cfg_data;
                    REG_CLIP_MAX_X:  clip_max_x  = {1'b0, i_cfg_data};
                    REG_CLIP_MIN_Y:  clip_min_y  = i_cfg_data;
                    REG_CLIP_MAX_Y:  clip_max_y  = {1'b0, i_cfg_data};
                    REG_LINE_STRIDE: line_stride = i_cfg_data;
                    default: ;
                endcase
            end
            // Queue the write for each accepted item
            if (i_in_valid && !i_in_stall) begin
                expected_writes.push_back(predict_pixel_write(i_in_data));
            end
            // Compare each accepted result with the oldest expected write
            if (i_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("result with no item queued", 1, 0);
                end else begin
                    want = expected_writes.pop_front();
                    if (i_out_data.write_enable !== want.write_enable)
                        report_mismatch("write_enable", i_out_data.write_enable,
                                        want.write_enable);
                    if (i_out_data.pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", i_out_data.pixel_address,
                                        want.pixel_address);
                    if (i_out_data.alpha_byte_address !== want.alpha_byte_address)
                        report_mismatch("alpha_byte_address", i_out_data.alpha_byte_address,
                                        want.alpha_byte_address);
                    if (i_out_data.alpha_low_nibble !== want.alpha_low_nibble)
                        report_mismatch("alpha_low_nibble", i_out_data.alpha_low_nibble,
                                        want.alpha_low_nibble);
                    if (i_out_data.new_rgb565 !== want.new_rgb565)
                        report_mismatch("new_rgb565", i_out_data.new_rgb565,
                                        want.new_rgb565);
                    if (i_out_data.new_alpha !== want.new_alpha)
                        report_mismatch("new_alpha", i_out_data.new_alpha, want.new_alpha);
                end
                o_checked++;
            end
            // Flag writes that never came out
            if (i_end_check && !end_done) begin
                if (expected_writes.size() != 0)
                    report_mismatch("items left without a result",
                                    expected_writes.size(), 0);
                end_done = 1'b1;
            end
        end
        o_pending = expected_writes.size();
    end

endmodule

[verif/clipped_pixel_alpha_blend_test.sv]
`timescale 1ns / 100ps
// Top of the pixel writer testbench: clock, reset, register phases, pixel stimulus, verdict
module clipped_pixel_alpha_blend_test;
    import cpab_pkg::*;

    localparam int          IDLE_PERCENT  = 37;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_ITEMS   = 65;
    localparam int          HOLD_PHASE    = 3;
    localparam int          HOLD_ITEMS    = 120;
    localparam logic [1:0]  MODE_NONE_2   = 2'd2;
    localparam logic [1:0]  MODE_NONE_3   = 2'd3;
    localparam int          COORD_LIMIT   = 2048;
    localparam int          REG_ALL_ONES  = 4095;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_pix_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_pix_out o_out_data;
    logic     i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic     end_check;

    int errors;
    int pending;
    int checked;

    // Window shadow used to aim coordinates at the clip edges
    int  win_min_x;
    int  win_max_x;
    int  win_min_y;
    int  win_max_y;
    int  setting_count;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_req;
    bit  hold_done;

    clipped_pixel_alpha_blend i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pixel_write_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_end_check (end_check),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Receiver: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("clipped_pixel_alpha_blend_test NOT OK");
                $finish;
            end
        end
    end

    // Offer one item, idling at random first, and hold it until accepted
    task automatic send_pixel(input t_pix_in p);
        @(negedge i_clk);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_px(input int x, input int y, input logic [31:0] src,
                           input logic [15:0] dst, input logic [2:0] da);
        t_pix_in p;
        p.pos_x      = COORD_BITS'(x);
        p.pos_y      = COORD_BITS'(y);
        p.src_argb   = src;
        p.dst_rgb565 = dst;
        p.dst_alpha  = da;
        send_pixel(p);
    endtask

    // Drop valid and wait until every queued write has come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_BITS'(val);
    endtask

    // Write every register, then release the write enable
    task automatic apply_settings(input logic [1:0] mode, input int min_x, input int max_x,
                                  input int min_y, input int max_y, input int stride);
        wait_idle();
        write_reg(REG_PIXEL_MODE, int'(mode));
        write_reg(REG_CLIP_MIN_X, min_x);
        write_reg(REG_CLIP_MAX_X, max_x);
        write_reg(REG_CLIP_MIN_Y, min_y);
        write_reg(REG_CLIP_MAX_Y, max_y);
        write_reg(REG_LINE_STRIDE, stride);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        win_min_x = min_x;
        win_max_x = max_x;
        win_min_y = min_y;
        win_max_y = max_y;
        setting_count++;
    endtask

    // Pick a clip range for one axis: full, empty, inverted, all ones or random
    task automatic pick_window(output int lo, output int hi);
        case ($urandom_range(0, 7))
            0: begin lo = 0; hi = COORD_LIMIT; end
            1: begin lo = $urandom_range(0, COORD_LIMIT); hi = lo; end
            2: begin lo = $urandom_range(1, COORD_LIMIT); hi = $urandom_range(0, lo - 1); end
            3: begin lo = 0; hi = REG_ALL_ONES; end
            default: begin
                lo = $urandom_range(0, COORD_LIMIT - 1);
                hi = $urandom_range(lo + 1, COORD_LIMIT);
            end
        endcase
    endtask

    task automatic random_settings();
        int          k;
        int          min_x;
        int          max_x;
        int          min_y;
        int          max_y;
        int          stride;
        logic [1:0]  mode;
        k = $urandom_range(0, 9);
        if (k < 4)       mode = MODE_BLEND;
        else if (k < 7)  mode = MODE_COPY;
        else if (k == 7) mode = MODE_NONE_2;
        else             mode = MODE_NONE_3;
        pick_window(min_x, max_x);
        pick_window(min_y, max_y);
        case ($urandom_range(0, 9))
            0:       stride = 0;
            1:       stride = COORD_LIMIT;
            2:       stride = REG_ALL_ONES;
            default: stride = $urandom_range(1, COORD_LIMIT);
        endcase
        apply_settings(mode, min_x, max_x, min_y, max_y, stride);
    endtask

    // Coordinate: full random, on a window edge, or inside the window
    function automatic logic [COORD_BITS-1:0] pick_coord(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return COORD_BITS'($urandom);
        if (r < 5) begin
            case ($urandom_range(0, 3))
                0:       return COORD_BITS'(lo - 1);
                1:       return COORD_BITS'(lo);
                2:       return COORD_BITS'(hi - 1);
                default: return COORD_BITS'(hi);
            endcase
        end
        if (hi > lo && lo < COORD_LIMIT)
            return COORD_BITS'($urandom_range(lo, (hi > COORD_LIMIT ? COORD_LIMIT : hi) - 1));
        return COORD_BITS'($urandom_range(0, COORD_LIMIT - 1));
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        p.pos_x    = pick_coord(win_min_x, win_max_x);
        p.pos_y    = pick_coord(win_min_y, win_max_y);
        p.src_argb = $urandom;
        case ($urandom_range(0, 9))
            0: p.src_argb[23:0] = 24'hffffff;
            1: p.src_argb[23:0] = 24'h000000;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:       p.dst_rgb565 = 16'hffff;
            1:       p.dst_rgb565 = 16'h0000;
            default: p.dst_rgb565 = 16'($urandom);
        endcase
        p.dst_alpha = 3'($urandom_range(0, 7));
        return p;
    endfunction

    initial begin
        int n;
        // Known values on every input from time zero
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_PIXEL_MODE;
        i_cfg_data    = '0;
        end_check     = 1'b0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        idle_cycles   = 0;
        win_min_x     = 0;
        win_max_x     = COORD_LIMIT;
        win_min_y     = 0;
        win_max_y     = COORD_LIMIT;
        setting_count = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: copy, full window, stride 720
        send_px(0, 0, 32'h0000_0000, 16'h0000, 3'd0);
        send_px(2047, 2047, 32'hffff_ffff, 16'hffff, 3'd7);
        send_px(-1, 5, 32'h8012_3456, 16'h1234, 3'd3);
        send_px(5, -2048, 32'h4012_3456, 16'h1234, 3'd3);
        send_px(-2048, -2048, 32'hffff_ffff, 16'hffff, 3'd7);
        send_px(1, 1, 32'h5a3c_96e1, 16'ha5a5, 3'd5);

        // Blend: transparent, opaque and each partial source alpha
        apply_settings(MODE_BLEND, 0, REG_ALL_ONES, 0, REG_ALL_ONES, 720);
        send_px(10, 20, 32'h1fff_ffff, 16'hffff, 3'd7);
        send_px(2047, 2047, 32'he012_3456, 16'h0000, 3'd0);
        send_px(3, 4, 32'h20ff_ffff, 16'h0000, 3'd0);
        send_px(4, 4, 32'h40ff_ffff, 16'hffff, 3'd7);
        send_px(5, 4, 32'h6000_0000, 16'hffff, 3'd7);
        send_px(6, 4, 32'h80ff_00ff, 16'h07e0, 3'd3);
        send_px(7, 4, 32'ha000_ff00, 16'hf81f, 3'd6);
        send_px(8, 4, 32'hc0ff_ffff, 16'h0000, 3'd7);
        send_px(9, 4, 32'hc000_0000, 16'hffff, 3'd1);

        // Disabled modes write nothing
        apply_settings(MODE_NONE_2, 0, REG_ALL_ONES, 0, REG_ALL_ONES, 720);
        send_px(100, 100, 32'hffff_ffff, 16'hffff, 3'd7);
        apply_settings(MODE_NONE_3, 0, REG_ALL_ONES, 0, REG_ALL_ONES, 720);
        send_px(100, 100, 32'hffff_ffff, 16'hffff, 3'd7);

        // Empty and inverted windows clip everything
        apply_settings(MODE_COPY, 100, 100, 100, 100, 720);
        send_px(100, 100, 32'hffff_ffff, 16'hffff, 3'd7);
        apply_settings(MODE_COPY, 500, 10, 500, 10, 720);
        send_px(200, 200, 32'hffff_ffff, 16'hffff, 3'd7);

        // Address wrap with an all-ones stride
        apply_settings(MODE_COPY, 0, REG_ALL_ONES, 0, REG_ALL_ONES, REG_ALL_ONES);
        send_px(2047, 2047, 32'h7654_3210, 16'h0000, 3'd0);
        send_px(2046, 2047, 32'h89ab_cdef, 16'h0000, 3'd0);

        // Random phases; one runs with a long output hold-off and no idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings();
            n = PHASE_ITEMS;
            if (ph == HOLD_PHASE) begin
                no_idle  = 1'b1;
                hold_req = 1'b1;
                n        = HOLD_ITEMS;
            end
            for (int i = 0; i < n; i++) send_pixel(rand_pixel());
            no_idle = 1'b0;
        end

        // Drain, flag leftovers, report
        wait_idle();
        end_check <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        $display("Checked %0d pixel write results over %0d register settings.",
                 checked, setting_count);
        $display("Covered copy, blend and disabled modes, clip edges, empty and inverted "
                 , "windows, address wrap and a long output hold-off.");
        if (errors == 0) begin
            $display("clipped_pixel_alpha_blend_test OK");
        end else begin
            $display("clipped_pixel_alpha_blend_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cpab_pkg.sv
rtl/clipped_pixel_alpha_blend.sv
rtl/cpab_checker.sv
verif/pixel_write_checker.sv
verif/clipped_pixel_alpha_blend_test.sv
